>>> design/hangul_syllable_to_jamo_top_macros.svh
// Assertion macros shared by the Hangul syllable to jamo design.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef HANGUL_SYLLABLE_TO_JAMO_TOP_MACROS_SVH
`define HANGUL_SYLLABLE_TO_JAMO_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSJ_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HSJ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/hsj_pkg.sv
// Shared types, constants and helper functions for the Hangul syllable to jamo design.
// No dependencies; used by hsj_front, hsj_queue, hsj_back and the top level.
package hsj_pkg;

  // Syllable block and jamo bases
  localparam logic [15:0] SYL_BASE   = 16'hAC00;
  localparam logic [15:0] SYL_LAST   = 16'hD7A3;
  localparam logic [15:0] LEAD_BASE  = 16'h1100;
  localparam logic [15:0] VOWEL_BASE = 16'h1161;
  localparam logic [15:0] TRAIL_BASE = 16'h11A7;

  // Divisors (21 * 28 and 28) and their scaled reciprocals, both rounded down
  localparam logic [9:0]  VT_COUNT    = 10'd588;
  localparam logic [4:0]  T_COUNT     = 5'd28;
  localparam logic [10:0] RECIP_VT    = 11'd1783;  // floor(2^20 / 588)
  localparam int          RECIP_VT_SH = 20;
  localparam logic [11:0] RECIP_T     = 12'd2340;  // floor(2^16 / 28)
  localparam int          RECIP_T_SH  = 16;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One character handed from the front to the back
  typedef struct packed {
    logic [3:0][7:0] bytes;   // raw bytes, entry 0 first
    logic [2:0]      count;   // bytes held, 1 to 4
    logic            syl;     // complete 3-byte Hangul syllable
    logic [13:0]     s_idx;   // code point minus SYL_BASE when syl is set
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_L,
    BK_FIX_L,
    BK_DIV_V,
    BK_FIX_V,
    BK_EMIT
  } back_st_t;

  // Character length from its lead byte; invalid leads count as one byte
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd1;
    if (b[7] == 1'b0)             len = 3'd1;
    else if (b[7:5] == 3'b110)    len = 3'd2;
    else if (b[7:4] == 4'b1110)   len = 3'd3;
    else if (b[7:3] == 5'b11110)  len = 3'd4;
    return len;
  endfunction

  // Byte pos (0..2) of the 3-byte UTF-8 form of code point u
  function automatic logic [7:0] jamo_byte(input logic [15:0] u, input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = {4'hE, u[15:12]};
      2'd1:    b = {2'b10, u[11:6]};
      default: b = {2'b10, u[5:0]};
    endcase
    return b;
  endfunction

  // Byte idx (0..8) of the lead, vowel and trail jamo sequence
  function automatic logic [7:0] syl_byte(input logic [4:0] lj, input logic [4:0] vj,
                                          input logic [4:0] tj, input logic [3:0] idx);
    logic [15:0] u;
    logic [1:0]  pos;
    case (idx)
      4'd0, 4'd1, 4'd2: u = LEAD_BASE + 16'(lj);
      4'd3, 4'd4, 4'd5: u = VOWEL_BASE + 16'(vj);
      default:          u = TRAIL_BASE + 16'(tj);
    endcase
    case (idx)
      4'd0, 4'd3, 4'd6: pos = 2'd0;
      4'd1, 4'd4, 4'd7: pos = 2'd1;
      default:          pos = 2'd2;
    endcase
    return jamo_byte(u, pos);
  endfunction

endpackage

>>> design/hsj_front.sv
// Front end: gathers UTF-8 bytes into characters and classifies each finished one.
// Depends on hsj_pkg and the shared assertion macros.
`include "hangul_syllable_to_jamo_top_macros.svh"

module hsj_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_text,
  output logic          push,
  output hsj_pkg::job_t push_job
);

  logic [2:0]      held_r, held_nxt;
  logic [2:0]      exp_r, exp_nxt;
  logic [3:0][7:0] buf_r, buf_nxt;

  logic            new_ch;
  logic [2:0]      base;
  logic [2:0]      exp_e;
  logic [2:0]      cnt;
  logic [3:0][7:0] bytes_c;
  logic            done;
  logic            flush;
  logic [15:0]     cp;
  logic [15:0]     s_full;

  always_comb begin
    new_ch  = (held_r == 3'd0) || (held_r > 3'd3) || (held_r >= exp_r);
    base    = new_ch ? 3'd0 : held_r;
    exp_e   = new_ch ? hsj_pkg::lead_len(in_byte) : exp_r;
    bytes_c = buf_r;
    bytes_c[base[1:0]] = in_byte;
    cnt     = base + 3'd1;
    done    = cnt >= exp_e;
    flush   = !done && in_end_of_text;
    cp      = {bytes_c[0][3:0], bytes_c[1][5:0], bytes_c[2][5:0]};
    s_full  = cp - hsj_pkg::SYL_BASE;

    push           = accept && (done || flush);
    push_job.bytes = bytes_c;
    push_job.count = cnt;
    push_job.syl   = done && (cnt == 3'd3) && (cp >= hsj_pkg::SYL_BASE) &&
                     (cp <= hsj_pkg::SYL_LAST);
    push_job.s_idx = s_full[13:0];

    held_nxt = held_r;
    exp_nxt  = exp_r;
    buf_nxt  = buf_r;
    if (accept) begin
      buf_nxt = bytes_c;
      if (done || flush) begin
        held_nxt = 3'd0;
        exp_nxt  = 3'd0;
      end else begin
        held_nxt = cnt;
        exp_nxt  = exp_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 3'd0;
      exp_r  <= 3'd0;
    end else begin
      held_r <= held_nxt;
      exp_r  <= exp_nxt;
    end
    buf_r <= buf_nxt;
  end

  `HSJ_ASSERT_NEXT(a_push_clears, clk, rst_n, push, held_r == 3'd0, "front: push left bytes held")
  `HSJ_ASSERT_IMPLY(a_held_short, clk, rst_n, held_r != 3'd0, held_r < exp_r,
                    "front: held bytes reached expected length")
  `HSJ_ASSERT_IMPLY(a_syl_three, clk, rst_n, push && push_job.syl, push_job.count == 3'd3,
                    "front: syllable job without three bytes")

endmodule

>>> design/hsj_queue.sv
// Four-entry job queue between the front and the back.
// Depends on hsj_pkg and the shared assertion macros.
`include "hangul_syllable_to_jamo_top_macros.svh"

module hsj_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hsj_pkg::job_t push_job,
  output logic          full,
  output logic          deq_valid,
  output hsj_pkg::job_t deq_job,
  input  logic          pop
);

  hsj_pkg::job_t                    mem_r [hsj_pkg::QDEPTH];
  logic [hsj_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [hsj_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [hsj_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  always_comb begin
    full       = cnt_r == hsj_pkg::QCNT_W'(hsj_pkg::QDEPTH);
    deq_valid  = cnt_r != '0;
    deq_job    = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + hsj_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + hsj_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + hsj_pkg::QCNT_W'(1);
    else if (pop && !push) cnt_nxt = cnt_r - hsj_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  `HSJ_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full || pop, "queue: push while full")
  `HSJ_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, deq_valid, "queue: pop while empty")
  `HSJ_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1,
                    cnt_r <= hsj_pkg::QCNT_W'(hsj_pkg::QDEPTH), "queue: count out of range")

endmodule

>>> design/hsj_back.sv
// Back end: splits syllables into jamo by reciprocal division and sends the output bytes.
// Depends on hsj_pkg and the shared assertion macros.
`include "hangul_syllable_to_jamo_top_macros.svh"

module hsj_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          deq_valid,
  input  hsj_pkg::job_t deq_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_run_last
);

  hsj_pkg::back_st_t st_r, st_nxt;
  hsj_pkg::job_t     job_r, job_nxt;
  logic [4:0]        q_r, q_nxt;
  logic [9:0]        rem_r, rem_nxt;
  logic [4:0]        lj_r, lj_nxt;
  logic [4:0]        vj_r, vj_nxt;
  logic [4:0]        tj_r, tj_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [3:0]        n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              load_ok;
  logic              take;
  logic              last_b;
  logic [24:0]       prod_l;
  logic [13:0]       rem_l;
  logic [21:0]       prod_v;
  logic [9:0]        rem_v;

  always_comb begin
    load_ok = !out_valid_r || !out_stall;
    prod_l  = 25'(job_r.s_idx) * 25'(hsj_pkg::RECIP_VT);
    rem_l   = job_r.s_idx - (14'(q_r) * 14'(hsj_pkg::VT_COUNT));
    prod_v  = 22'(rem_r) * 22'(hsj_pkg::RECIP_T);
    rem_v   = rem_r - (10'(q_r) * 10'(hsj_pkg::T_COUNT));
    last_b  = idx_r == (n_r - 4'd1);

    st_nxt        = st_r;
    job_nxt       = job_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    lj_nxt        = lj_r;
    vj_nxt        = vj_r;
    tj_nxt        = tj_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = load_ok ? 1'b0 : out_valid_r;
    take          = 1'b0;

    case (st_r)
      hsj_pkg::BK_IDLE: begin
        take = deq_valid;
      end
      hsj_pkg::BK_DIV_L: begin
        // estimate of s / 588, low by at most one
        q_nxt  = prod_l[hsj_pkg::RECIP_VT_SH +: 5];
        st_nxt = hsj_pkg::BK_FIX_L;
      end
      hsj_pkg::BK_FIX_L: begin
        if (rem_l >= 14'(hsj_pkg::VT_COUNT)) begin
          lj_nxt  = q_r + 5'd1;
          rem_nxt = 10'(rem_l - 14'(hsj_pkg::VT_COUNT));
        end else begin
          lj_nxt  = q_r;
          rem_nxt = rem_l[9:0];
        end
        st_nxt = hsj_pkg::BK_DIV_V;
      end
      hsj_pkg::BK_DIV_V: begin
        q_nxt  = prod_v[hsj_pkg::RECIP_T_SH +: 5];
        st_nxt = hsj_pkg::BK_FIX_V;
      end
      hsj_pkg::BK_FIX_V: begin
        if (rem_v >= 10'(hsj_pkg::T_COUNT)) begin
          vj_nxt = q_r + 5'd1;
          tj_nxt = 5'(rem_v - 10'(hsj_pkg::T_COUNT));
        end else begin
          vj_nxt = q_r;
          tj_nxt = rem_v[4:0];
        end
        // drop the trailing jamo when there is none
        n_nxt   = (tj_nxt != 5'd0) ? 4'd9 : 4'd6;
        idx_nxt = 4'd0;
        st_nxt  = hsj_pkg::BK_EMIT;
      end
      hsj_pkg::BK_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = job_r.syl ? hsj_pkg::syl_byte(lj_r, vj_r, tj_r, idx_r)
                                    : job_r.bytes[idx_r[1:0]];
          out_last_nxt  = last_b;
          if (last_b) begin
            st_nxt = hsj_pkg::BK_IDLE;
            take   = deq_valid;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      default: begin
        st_nxt = hsj_pkg::BK_IDLE;
      end
    endcase

    if (take) begin
      job_nxt = deq_job;
      idx_nxt = 4'd0;
      n_nxt   = {1'b0, deq_job.count};
      st_nxt  = deq_job.syl ? hsj_pkg::BK_DIV_L : hsj_pkg::BK_EMIT;
    end
    pop = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= hsj_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r      <= job_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    lj_r       <= lj_nxt;
    vj_r       <= vj_nxt;
    tj_r       <= tj_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

  `HSJ_ASSERT_IMPLY(a_emit_idx, clk, rst_n, st_r == hsj_pkg::BK_EMIT, idx_r < n_r,
                    "back: byte index past job length")
  `HSJ_ASSERT_IMPLY(a_div_syl, clk, rst_n, st_r == hsj_pkg::BK_DIV_L, job_r.syl,
                    "back: division on a pass-through job")
  `HSJ_ASSERT_NEXT(a_fix_range, clk, rst_n, st_r == hsj_pkg::BK_FIX_V,
                   (lj_r <= 5'd18) && (vj_r <= 5'd20) && (tj_r <= 5'd27),
                   "back: jamo index out of range")

endmodule

>>> design/hangul_syllable_to_jamo_top.sv
// Top level of the Hangul syllable to jamo converter over a UTF-8 byte stream.
// Depends on hsj_pkg, hsj_front, hsj_queue and hsj_back.
//
//   channel   ports                                      role
//   input     in_valid in_stall in_byte in_end_of_text   UTF-8 text bytes in
//   output    out_valid out_stall out_byte out_run_last  converted bytes out
//
// Flow: the front takes one request per cycle while the job queue has room;
// the back sends one byte per cycle unless stalled, a pass-through job right behind
// the last one, a Hangul syllable after reciprocal division (six or nine bytes).
// Reset (rst_n low, synchronous) clears gather counters, queue and sequencer.
// out_stall holds the output register and backs up the queue; in_stall rises
// only while the queue is full.

module hangul_syllable_to_jamo_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  logic          accept;
  logic          push;
  hsj_pkg::job_t push_job;
  logic          full;
  logic          deq_valid;
  hsj_pkg::job_t deq_job;
  logic          pop;

  // Take a request whenever the queue can hold whatever it may finish
  assign in_stall = full;
  assign accept   = in_valid && !full;

  hsj_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_text (in_end_of_text),
    .push           (push),
    .push_job       (push_job)
  );

  hsj_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (full),
    .deq_valid (deq_valid),
    .deq_job   (deq_job),
    .pop       (pop)
  );

  hsj_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .deq_valid    (deq_valid),
    .deq_job      (deq_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule
